// ===== hw/rtl/mdtri_pkg.sv =====
// Package for the multi-domain trace request issuer: sizes, op codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mdtri_pkg;
  localparam int unsigned Domains    = 4;
  localparam int unsigned TraceDepth = 1024;
  localparam int unsigned AddrBits   = 32;
  localparam int unsigned DomW       = $clog2(Domains);
  localparam int unsigned IdxW       = $clog2(TraceDepth);
  localparam int unsigned MemAw      = DomW + IdxW;
  localparam int unsigned LenW       = IdxW + 1;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [1:0] OpWrite  = 2'd0;
  localparam logic [1:0] OpStart  = 2'd1;
  localparam logic [1:0] OpTick   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [CfgIdxW-1:0] CfgDomains = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLimit   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgMode    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgLen0    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgLen1    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgLen2    = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgLen3    = 3'd6;

  typedef enum logic [3:0] {
    StIdle, StStartRd, StStartLd, StVisit, StLoad, StStore, StAdvance,
    StFetchRd, StFetchLd, StStatus
  } ctrl_state_e;

  typedef struct packed {
    logic           start_clear;  // clear per-domain state, pointer, count
    logic           sel_cur;      // latch a domain from the walk pointer
    logic           set_dom;      // latch domain from dom_val
    logic [DomW-1:0] dom_val;
    logic           mem_rd;       // read entry of current domain
    logic           mem_ld;       // load read data into current domain
    logic           bubble_dec;
    logic           issue_load;
    logic           issue_store;
    logic           advance;      // step entry index, wrap / finish
    logic           status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic           done;
    logic           finished;
    logic           has_bubble;
    logic           ld_wait;
    logic           st_wait;
    logic           acc;
    logic           limit_hit;
    logic           finish_now;   // advance would finish the domain
    logic           interleaved;  // walk mode register
    logic [DomW-1:0] cur;
    logic [DomW:0]  n_act;
  } ctrl_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/multi_domain_trace_request_issuer_core.sv =====
// Trace request issuer: a trace write goes straight to the status result, start
// replay reads and loads the first entry of each active domain, and a tick walks
// the visited domains (visit, load, store, advance, entry read and load) before status.
// The controller handles one transaction at a time; busy covers it.
// Results are strobed for one cycle and cannot be stalled.
// Reset (rst_ni low, asynchronous) clears control state and configuration.
`timescale 1ns / 1ps
`default_nettype none
module multi_domain_trace_request_issuer_core
  import mdtri_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [1:0]          op_i,
  input  wire logic [1:0]          entry_domain_i,
  input  wire logic [IdxW-1:0]     entry_index_i,
  input  wire logic [15:0]         entry_bubbles_i,
  input  wire logic [AddrBits-1:0] entry_load_address_i,
  input  wire logic                entry_has_load_i,
  input  wire logic [AddrBits-1:0] entry_store_address_i,
  input  wire logic                entry_has_store_i,
  input  wire logic [Domains-1:0]  accept_mask_i,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [31:0]         cfg_data_i,
  output logic                     result_valid_o,
  output logic                     kind_o,
  output logic [AddrBits-1:0]      request_address_o,
  output logic                     request_is_write_o,
  output logic [1:0]               request_domain_o,
  output logic                     all_done_o,
  output logic                     last_o
);
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic go, rr;
  logic [Domains-1:0] acc_q;

  assign go = start && !busy;
  assign cfg_ready_o = 1'b1;

  // hold the accept mask for the whole tick
  always_ff @(posedge clk_i) begin
    if (go) acc_q <= accept_mask_i;
  end
  assign rr = !sts.interleaved;

  mdtri_ctrl u_ctrl (
    .clk_i, .rst_ni, .go_i(go), .op_i, .rr_i(rr), .sts_i(sts),
    .cmd_o(cmd), .busy_o(busy)
  );

  mdtri_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .wr_en_i(go && op_i == OpWrite),
    .entry_domain_i, .entry_index_i, .entry_bubbles_i, .entry_load_address_i,
    .entry_has_load_i, .entry_store_address_i, .entry_has_store_i,
    .accept_mask_i(acc_q), .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .out_valid_o(result_valid_o), .kind_o, .request_address_o,
    .request_is_write_o, .request_domain_o, .all_done_o, .last_o
  );
endmodule
`default_nettype wire

// ===== hw/rtl/mdtri_datapath.sv =====
// Datapath: trace memories, per-domain replay state, request counter,
// walk pointer and result register. Uses mdtri_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mdtri_datapath
  import mdtri_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire ctrl_cmd_t            cmd_i,
  output ctrl_sts_t                 sts_o,
  input  wire logic                 wr_en_i,
  input  wire logic [1:0]           entry_domain_i,
  input  wire logic [IdxW-1:0]      entry_index_i,
  input  wire logic [15:0]          entry_bubbles_i,
  input  wire logic [AddrBits-1:0]  entry_load_address_i,
  input  wire logic                 entry_has_load_i,
  input  wire logic [AddrBits-1:0]  entry_store_address_i,
  input  wire logic                 entry_has_store_i,
  input  wire logic [Domains-1:0]   accept_mask_i,
  input  wire logic                 cfg_valid_i,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [31:0]          cfg_data_i,
  output logic                      out_valid_o,
  output logic                      kind_o,
  output logic [AddrBits-1:0]       request_address_o,
  output logic                      request_is_write_o,
  output logic [1:0]                request_domain_o,
  output logic                      all_done_o,
  output logic                      last_o
);
  logic [17:0]         ctl_mem [2**MemAw];
  logic [AddrBits-1:0] lda_mem [2**MemAw];
  logic [AddrBits-1:0] sta_mem [2**MemAw];
  logic [17:0]         ctl_rd_q;
  logic [AddrBits-1:0] lda_rd_q, sta_rd_q;

  logic [2:0]  dom_use_q;
  logic [31:0] limit_q;
  logic        mode_q;
  logic [LenW-1:0] len_q [Domains];

  logic [IdxW-1:0]     entry_q [Domains];
  logic [15:0]         bub_q   [Domains];
  logic [Domains-1:0]  ldw_q, stw_q, fin_q;
  logic [AddrBits-1:0] ldad_q [Domains];
  logic [AddrBits-1:0] stad_q [Domains];
  logic [DomW-1:0]     next_q, cur_q;
  logic [31:0]         issued_q;

  logic [DomW:0]   n_act;
  logic [LenW-1:0] cur_len;
  logic [DomW-1:0] walk;
  logic            fin_all;
  logic [MemAw-1:0] rd_addr;

  // active domain count, saturated (0 reads as 1); clamped current length, walk pointer
  always_comb begin
    n_act = (dom_use_q == 3'd0) ? (DomW+1)'(1)
          : ({1'b0, dom_use_q} > 4'(Domains)) ? (DomW+1)'(Domains)
          : (DomW+1)'(dom_use_q);
    cur_len = (len_q[cur_q] == '0) ? LenW'(1)
            : (len_q[cur_q] > LenW'(TraceDepth)) ? LenW'(TraceDepth) : len_q[cur_q];
    walk = ({1'b0, next_q} >= n_act) ? '0 : next_q;
    fin_all = 1'b1;
    for (int d = 0; d < Domains; d++) begin
      if ((DomW+1)'(d) < n_act && !fin_q[d]) fin_all = 1'b0;
    end
    rd_addr = {cur_q, entry_q[cur_q]};
  end

  always_comb begin
    sts_o.limit_hit  = (limit_q != '0) && (issued_q >= limit_q);
    sts_o.done       = (limit_q != '0) ? sts_o.limit_hit : fin_all;
    sts_o.finished   = fin_q[cur_q];
    sts_o.has_bubble = bub_q[cur_q] != '0;
    sts_o.ld_wait    = ldw_q[cur_q];
    sts_o.st_wait    = stw_q[cur_q];
    sts_o.acc        = accept_mask_i[cur_q];
    sts_o.finish_now = ({1'b0, entry_q[cur_q]} + LenW'(1) >= cur_len) && (limit_q == '0);
    sts_o.interleaved = mode_q;
    sts_o.cur        = cur_q;
    sts_o.n_act      = n_act;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      ctl_mem[{entry_domain_i, entry_index_i}] <=
        {entry_has_store_i, entry_has_load_i, entry_bubbles_i};
      lda_mem[{entry_domain_i, entry_index_i}] <= entry_load_address_i;
      sta_mem[{entry_domain_i, entry_index_i}] <= entry_store_address_i;
    end
    if (cmd_i.mem_rd) begin
      ctl_rd_q <= ctl_mem[rd_addr];
      lda_rd_q <= lda_mem[rd_addr];
      sta_rd_q <= sta_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dom_use_q <= 3'd4;
      limit_q   <= '0;
      mode_q    <= 1'b0;
      for (int d = 0; d < Domains; d++) begin
        len_q[d]  <= LenW'(1);
        entry_q[d] <= '0;
        bub_q[d]  <= '0;
        ldad_q[d] <= '0;
        stad_q[d] <= '0;
      end
      ldw_q <= '0; stw_q <= '0; fin_q <= '0;
      next_q <= '0; cur_q <= '0; issued_q <= '0;
      out_valid_o <= 1'b0;
      kind_o <= 1'b0; request_address_o <= '0; request_is_write_o <= 1'b0;
      request_domain_o <= '0; all_done_o <= 1'b0; last_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgDomains: dom_use_q <= cfg_data_i[2:0];
          CfgLimit:   limit_q   <= cfg_data_i;
          CfgMode:    mode_q    <= cfg_data_i[0];
          CfgLen0:    len_q[0]  <= cfg_data_i[LenW-1:0];
          CfgLen1:    len_q[1]  <= cfg_data_i[LenW-1:0];
          CfgLen2:    len_q[2]  <= cfg_data_i[LenW-1:0];
          CfgLen3:    len_q[3]  <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      out_valid_o <= cmd_i.issue_load || cmd_i.issue_store || cmd_i.status;
      if (cmd_i.start_clear) begin
        entry_q <= '{default: '0};
        bub_q   <= '{default: '0};
        ldad_q  <= '{default: '0};
        stad_q  <= '{default: '0};
        ldw_q <= '0; stw_q <= '0; fin_q <= '0;
        next_q <= '0; issued_q <= '0;
      end
      if (cmd_i.set_dom) cur_q <= cmd_i.dom_val;
      if (cmd_i.sel_cur) begin
        cur_q  <= walk;
        next_q <= ({1'b0, walk} + (DomW+1)'(1) >= n_act) ? '0 : walk + DomW'(1);
      end
      if (cmd_i.mem_ld) begin
        bub_q[cur_q]  <= ctl_rd_q[15:0];
        ldw_q[cur_q]  <= ctl_rd_q[16];
        stw_q[cur_q]  <= ctl_rd_q[17];
        ldad_q[cur_q] <= lda_rd_q;
        stad_q[cur_q] <= sta_rd_q;
      end
      if (cmd_i.bubble_dec) bub_q[cur_q] <= bub_q[cur_q] - 16'd1;
      if (cmd_i.issue_load || cmd_i.issue_store) begin
        issued_q <= issued_q + 32'd1;
        kind_o <= 1'b0; last_o <= 1'b0; all_done_o <= 1'b0;
        request_domain_o <= 2'(cur_q);
        request_is_write_o <= cmd_i.issue_store;
        request_address_o <= cmd_i.issue_store ? stad_q[cur_q] : ldad_q[cur_q];
        if (cmd_i.issue_load) ldw_q[cur_q] <= 1'b0;
        else stw_q[cur_q] <= 1'b0;
      end
      if (cmd_i.advance) begin
        if ({1'b0, entry_q[cur_q]} + LenW'(1) >= cur_len) begin
          entry_q[cur_q] <= '0;
          if (limit_q == '0) fin_q[cur_q] <= 1'b1;
        end else begin
          entry_q[cur_q] <= entry_q[cur_q] + IdxW'(1);
        end
      end
      if (cmd_i.status) begin
        kind_o <= 1'b1; last_o <= 1'b1; all_done_o <= sts_o.done;
        request_domain_o <= '0; request_is_write_o <= 1'b0;
        request_address_o <= '0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mdtri_ctrl.sv =====
// Controller: sequences start replay, the domain walk of a tick and the
// status result. Uses mdtri_pkg; drives mdtri_datapath by command struct.
`timescale 1ns / 1ps
`default_nettype none
module mdtri_ctrl
  import mdtri_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       go_i,
  input  wire logic [1:0] op_i,
  input  wire logic       rr_i,
  input  wire ctrl_sts_t  sts_i,
  output ctrl_cmd_t       cmd_o,
  output logic            busy_o
);
  ctrl_state_e state_q, state_d;
  logic [DomW:0] cnt_q, cnt_d;   // domains tried / start index

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    logic more;
    more    = (cnt_q + (DomW+1)'(1)) < sts_i.n_act;
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    busy_o  = state_q != StIdle;
    unique case (state_q)
      StIdle: begin
        if (go_i) begin
          cnt_d = '0;
          unique case (op_i)
            OpStart: begin
              cmd_o.start_clear = 1'b1;
              cmd_o.set_dom = 1'b1;
              state_d = StStartRd;
            end
            OpTick: state_d = sts_i.done ? StStatus : StVisit;
            default: state_d = StStatus;
          endcase
          if (op_i == OpTick && !sts_i.done) cmd_o.sel_cur = 1'b1;
        end
      end
      StStartRd: begin
        cmd_o.mem_rd = 1'b1;
        state_d = StStartLd;
      end
      StStartLd: begin
        cmd_o.mem_ld = 1'b1;
        if (more) begin
          cnt_d = cnt_q + (DomW+1)'(1);
          cmd_o.set_dom = 1'b1;
          cmd_o.dom_val = DomW'(cnt_d);
          state_d = StStartRd;
        end else begin
          state_d = StStatus;
        end
      end
      StVisit: begin
        if (sts_i.finished) state_d = StAdvance;
        else if (sts_i.has_bubble) begin
          cmd_o.bubble_dec = 1'b1;
          state_d = rr_i ? StStatus : StAdvance;
        end else state_d = StLoad;
        // the StAdvance choice above is replaced here by the "next domain" step
        if (sts_i.finished || (sts_i.has_bubble && !rr_i)) begin
          state_d = more ? StVisit : StStatus;
          if (more) begin
            cnt_d = cnt_q + (DomW+1)'(1);
            cmd_o.sel_cur = 1'b1;
          end
        end
      end
      StLoad: begin
        if (sts_i.ld_wait && !sts_i.acc) begin
          state_d = (rr_i || !more) ? StStatus : StVisit;
          if (!rr_i && more) begin
            cnt_d = cnt_q + (DomW+1)'(1);
            cmd_o.sel_cur = 1'b1;
          end
        end else if (sts_i.ld_wait) begin
          cmd_o.issue_load = 1'b1;
          state_d = StStore;
        end else state_d = StStore;
      end
      StStore: begin
        if (sts_i.limit_hit) state_d = StStatus;
        else if (sts_i.st_wait && !sts_i.acc) begin
          state_d = (rr_i || !more) ? StStatus : StVisit;
          if (!rr_i && more) begin
            cnt_d = cnt_q + (DomW+1)'(1);
            cmd_o.sel_cur = 1'b1;
          end
        end else if (sts_i.st_wait) begin
          cmd_o.issue_store = 1'b1;
          state_d = StAdvance;
        end else state_d = StAdvance;
      end
      StAdvance: begin
        if (sts_i.limit_hit) state_d = StStatus;
        else begin
          cmd_o.advance = 1'b1;
          state_d = sts_i.finish_now ? StFetchLd : StFetchRd;
          if (sts_i.finish_now) begin
            // finished: no fetch, continue the walk in either mode
            state_d = more ? StVisit : StStatus;
            if (more) begin
              cnt_d = cnt_q + (DomW+1)'(1);
              cmd_o.sel_cur = 1'b1;
            end
          end
        end
      end
      StFetchRd: begin
        cmd_o.mem_rd = 1'b1;
        state_d = StFetchLd;
      end
      StFetchLd: begin
        cmd_o.mem_ld = 1'b1;
        state_d = (rr_i || !more) ? StStatus : StVisit;
        if (!rr_i && more) begin
          cnt_d = cnt_q + (DomW+1)'(1);
          cmd_o.sel_cur = 1'b1;
        end
      end
      StStatus: begin
        cmd_o.status = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

// ===== hw/rtl/mdtri_checker.sv =====
// Port-level checker for the trace request issuer, bound to the top level.
// Uses mdtri_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mdtri_checker
  import mdtri_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic result_valid_o,
  input wire logic kind_o,
  input wire logic last_o,
  input wire logic all_done_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accept without busy");
  a_last_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (kind_o == last_o)) else $error("last mismatch");
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !kind_o |-> !all_done_o) else $error("done on request");
  a_status_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_o |-> !busy) else $error("busy during status");
endmodule

bind multi_domain_trace_request_issuer_core mdtri_checker u_chk (
  .clk_i, .rst_ni, .start, .busy, .result_valid_o, .kind_o, .last_o, .all_done_o
);
`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the multi-domain trace request issuer core.
// Holds a scoreboard class that predicts issued requests and status results.
// Depends on mdtri_pkg and multi_domain_trace_request_issuer_core.
`timescale 1ns / 1ps
`default_nettype none

class TraceIssueScoreboard;
  typedef struct packed {
    logic        kind;
    logic [31:0] addr;
    logic        is_write;
    logic [1:0]  dom;
    logic        done;
    logic        last;
  } issue_rec_t;

  issue_rec_t  expected_q[$];
  int unsigned mismatches;
  int unsigned requests_seen;
  int unsigned results_seen;

  // trace memory and per-domain replay state
  logic [17:0] ctl_mem[4096];
  logic [31:0] ld_mem[4096];
  logic [31:0] st_mem[4096];
  int unsigned cur_entry[4];
  int unsigned bubbles[4];
  bit          ld_wait[4];
  bit          st_wait[4];
  logic [31:0] ld_addr[4];
  logic [31:0] st_addr[4];
  bit          finished[4];
  int unsigned next_dom;
  int unsigned issued;

  // configuration copy
  int unsigned dom_cfg;
  int unsigned limit;
  bit          interleaved;
  int unsigned len_cfg[4];

  function new();
    for (int i = 0; i < 4096; i++) begin
      ctl_mem[i] = '0;
      ld_mem[i]  = '0;
      st_mem[i]  = '0;
    end
    for (int d = 0; d < 4; d++) begin
      cur_entry[d] = 0; bubbles[d] = 0; ld_wait[d] = 0; st_wait[d] = 0;
      ld_addr[d] = '0; st_addr[d] = '0; finished[d] = 0; len_cfg[d] = 1;
    end
    next_dom = 0; issued = 0; dom_cfg = 4; limit = 0; interleaved = 0;
    mismatches = 0; requests_seen = 0; results_seen = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] data);
    case (idx) inside
      mdtri_pkg::CfgDomains: dom_cfg = data[2:0];
      mdtri_pkg::CfgLimit:   limit = data;
      mdtri_pkg::CfgMode:    interleaved = data[0];
      mdtri_pkg::CfgLen0, mdtri_pkg::CfgLen1, mdtri_pkg::CfgLen2, mdtri_pkg::CfgLen3:
        len_cfg[idx - mdtri_pkg::CfgLen0] = data[10:0];
      default: ;
    endcase
  endfunction

  function int unsigned active_count();
    if (dom_cfg == 0) return 1;
    return (dom_cfg > 4) ? 4 : dom_cfg;
  endfunction

  function int unsigned trace_len(int unsigned d);
    if (len_cfg[d] == 0) return 1;
    return (len_cfg[d] > 1024) ? 1024 : len_cfg[d];
  endfunction

  function void load_entry(int unsigned d);
    int unsigned a;
    a = d * 1024 + (cur_entry[d] % 1024);
    bubbles[d] = ctl_mem[a][15:0];
    ld_wait[d] = ctl_mem[a][16];
    st_wait[d] = ctl_mem[a][17];
    ld_addr[d] = ld_mem[a];
    st_addr[d] = st_mem[a];
  endfunction

  function bit replay_done();
    if (limit > 0) return issued >= limit;
    for (int d = 0; d < active_count(); d++)
      if (!finished[d]) return 0;
    return 1;
  endfunction

  function bit limit_reached();
    return limit > 0 && issued >= limit;
  endfunction

  function void push_request(logic [31:0] addr, bit wr, int unsigned d);
    issue_rec_t r;
    r = '{kind: 1'b0, addr: addr, is_write: wr, dom: d[1:0], done: 1'b0, last: 1'b0};
    expected_q = {expected_q, r};
  endfunction

  function void walk_tick(logic [3:0] accept);
    int unsigned n, tried, d, idx;
    bit rr, acc;
    n = active_count();
    rr = !interleaved;
    tried = 0;
    if (replay_done()) return;
    while (tried < n) begin
      d = next_dom;
      if (d >= n) d = 0;
      next_dom = (d + 1 >= n) ? 0 : d + 1;
      tried++;
      if (finished[d]) continue;
      if (bubbles[d] > 0) begin
        bubbles[d]--;
        if (rr) break;
        continue;
      end
      acc = accept[d];
      if (ld_wait[d]) begin
        if (!acc) begin
          if (rr) break;
          continue;
        end
        push_request(ld_addr[d], 1'b0, d);
        ld_wait[d] = 0;
        issued++;
        if (limit_reached()) return;
      end
      if (st_wait[d]) begin
        if (!acc) begin
          if (rr) break;
          continue;
        end
        push_request(st_addr[d], 1'b1, d);
        st_wait[d] = 0;
        issued++;
        if (limit_reached()) return;
      end
      idx = cur_entry[d] + 1;
      if (idx >= trace_len(d)) begin
        idx = 0;
        cur_entry[d] = 0;
        // a finished domain lets the walk go on even in round-robin mode
        if (limit == 0) begin
          finished[d] = 1;
          continue;
        end
      end
      cur_entry[d] = idx;
      load_entry(d);
      if (rr) break;
    end
  endfunction

  function void note_item(logic [1:0] op, logic [1:0] edom, logic [9:0] eidx,
                          logic [15:0] ebub, logic [31:0] eld, logic ehas_ld,
                          logic [31:0] est, logic ehas_st, logic [3:0] accept);
    issue_rec_t r;
    int unsigned a, n;
    case (op)
      mdtri_pkg::OpWrite: begin
        a = edom * 1024 + eidx;
        ctl_mem[a] = {ehas_st, ehas_ld, ebub};
        ld_mem[a]  = eld;
        st_mem[a]  = est;
      end
      mdtri_pkg::OpStart: begin
        n = active_count();
        for (int d = 0; d < 4; d++) begin
          cur_entry[d] = 0;
          finished[d] = 0;
          if (d < n) load_entry(d);
          else begin
            bubbles[d] = 0; ld_wait[d] = 0; st_wait[d] = 0;
            ld_addr[d] = '0; st_addr[d] = '0;
          end
        end
        next_dom = 0;
        issued = 0;
      end
      mdtri_pkg::OpTick: walk_tick(accept);
      default: ;
    endcase
    r = '{kind: 1'b1, addr: '0, is_write: 1'b0, dom: 2'd0,
          done: replay_done(), last: 1'b1};
    expected_q = {expected_q, r};
  endfunction

  function void check_result(issue_rec_t got);
    issue_rec_t want;
    results_seen++;
    if (!got.kind) requests_seen++;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result kind=%0b addr=%h", $time, got.kind, got.addr);
      return;
    end
    want = expected_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: mismatch exp kind=%0b addr=%h wr=%0b dom=%0d done=%0b last=%0b",
                 $time, want.kind, want.addr, want.is_write, want.dom, want.done,
                 want.last);
        $display("%0t:          got kind=%0b addr=%h wr=%0b dom=%0d done=%0b last=%0b",
                 $time, got.kind, got.addr, got.is_write, got.dom, got.done,
                 got.last);
      end
    end
  endfunction
endclass

module tb;
  import mdtri_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [1:0]          op_i = OpTick;
  logic [1:0]          entry_domain_i = '0;
  logic [IdxW-1:0]     entry_index_i = '0;
  logic [15:0]         entry_bubbles_i = '0;
  logic [AddrBits-1:0] entry_load_address_i = '0;
  logic                entry_has_load_i = 1'b0;
  logic [AddrBits-1:0] entry_store_address_i = '0;
  logic                entry_has_store_i = 1'b0;
  logic [Domains-1:0]  accept_mask_i = '0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [31:0]         cfg_data_i = '0;
  logic                result_valid_o;
  logic                kind_o;
  logic [AddrBits-1:0] request_address_o;
  logic                request_is_write_o;
  logic [1:0]          request_domain_o;
  logic                all_done_o;
  logic                last_o;

  TraceIssueScoreboard issue_sb = new();
  bit          gaps_on = 1'b1;
  int unsigned items_sent = 0;

  multi_domain_trace_request_issuer_core u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o)
      issue_sb.check_result('{kind: kind_o, addr: request_address_o,
                              is_write: request_is_write_o, dom: request_domain_o,
                              done: all_done_o, last: last_o});
  end

  initial begin
    #20_000_000;
    $display("tb failed");
    $finish;
  end

  // leave start high after the transaction; the caller lowers it
  task automatic send_item(logic [1:0] op, logic [1:0] edom, logic [9:0] eidx,
                           logic [15:0] ebub, logic [31:0] eld, logic ehas_ld,
                           logic [31:0] est, logic ehas_st, logic [3:0] accept);
    if (gaps_on && $urandom_range(99) < 8) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    op_i <= op;
    entry_domain_i <= edom;
    entry_index_i <= eidx;
    entry_bubbles_i <= ebub;
    entry_load_address_i <= eld;
    entry_has_load_i <= ehas_ld;
    entry_store_address_i <= est;
    entry_has_store_i <= ehas_st;
    accept_mask_i <= accept;
    do @(posedge clk_i); while (busy);
    issue_sb.note_item(op, edom, eidx, ebub, eld, ehas_ld, est, ehas_st, accept);
    items_sent++;
  endtask

  task automatic send_tick(logic [3:0] accept);
    send_item(OpTick, 2'($urandom), 10'($urandom), 16'($urandom), $urandom,
              1'($urandom), $urandom, 1'($urandom), accept);
  endtask

  task automatic send_entry(logic [1:0] d, logic [9:0] idx, logic [15:0] bub);
    // domain 0 entries always carry a load so a long trace stops on the limit
    send_item(OpWrite, d, idx, bub, $urandom, (d == 0) ? 1'b1 : 1'($urandom),
              $urandom, 1'($urandom), 4'($urandom));
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    issue_sb.write_reg(idx, data);
  endtask

  task automatic set_phase(int unsigned doms, logic [31:0] lim, bit mode,
                           int unsigned l0, int unsigned l1, int unsigned l2,
                           int unsigned l3);
    start <= 1'b0;
    while (issue_sb.pending() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_write(CfgDomains, doms);
    cfg_write(CfgLimit, lim);
    cfg_write(CfgMode, 32'(mode));
    cfg_write(CfgLen0, l0);
    cfg_write(CfgLen1, l1);
    cfg_write(CfgLen2, l2);
    cfg_write(CfgLen3, l3);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_items(int unsigned count, bit allow_start);
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 70)
        send_tick(($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom) | 4'($urandom));
      else if (pick < 85)
        send_entry(2'($urandom), 10'($urandom_range(8)), 16'($urandom_range(3)));
      else if (pick < 95 && allow_start)
        send_item(OpStart, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
      else
        send_item(OpUnused, 2'($urandom), 10'($urandom), 16'($urandom), $urandom,
                  1'($urandom), $urandom, 1'($urandom), 4'($urandom));
    end
  endtask

  task automatic phase_run(int unsigned count);
    send_item(OpStart, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
    random_items(count, 1'b1);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: tick on the reset state, unknown op, field extremes
    send_tick(4'hF);
    send_item(OpUnused, 2'd3, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
              1'b1, 4'hF);
    send_item(OpWrite, 2'd3, 10'd1023, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
              1'b1, 4'h0);
    send_item(OpWrite, 2'd2, 10'd1023, 16'h0000, 32'h0000_0000, 1'b0, 32'h0000_0000,
              1'b0, 4'hF);
    // fill entries 0..8 of every domain so no replay reads an empty slot
    for (int i = 0; i <= 8; i++)
      for (int d = 0; d < 4; d++)
        send_entry(2'(d), 10'(i), 16'($urandom_range(2)));
    send_item(OpWrite, 2'd1, 10'd2, 16'hFFFF, 32'h0, 1'b1, 32'hFFFF_FFFF, 1'b1, 4'h0);
    send_item(OpWrite, 2'd2, 10'd1, 16'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1, 4'h0);

    set_phase(4, 32'd0, 1'b0, 3, 2, 1, 4);
    send_item(OpStart, '0, '0, '0, '0, 1'b0, '0, 1'b0, '0);
    repeat (4) send_tick(4'h0);
    repeat (20) send_tick(4'hF);
    send_entry(2'd1, 10'd2, 16'd1);
    random_items(10, 1'b1);

    gaps_on = 1'b0;
    set_phase(4, 32'd0, 1'b1, 1, 5, 3, 2);
    phase_run(25);

    gaps_on = 1'b1;
    set_phase(1, 32'd8, 1'b0, 1024, 1, 1, 1);
    phase_run(20);

    set_phase(2, 32'hFFFF_FFFF, 1'b1, 6, 1, 8, 3);
    phase_run(25);

    set_phase(4, 32'd13, 1'b1, $urandom_range(1, 8), $urandom_range(1, 8),
              $urandom_range(1, 8), $urandom_range(1, 8));
    phase_run(20);

    set_phase(4, 32'hFFFF_FFFF, 1'b0, $urandom_range(1, 8), $urandom_range(1, 8),
              $urandom_range(1, 8), $urandom_range(1, 8));
    phase_run(20);

    // fewer domains with a possibly stale pointer, ticks before the restart
    set_phase(2, 32'd0, 1'b1, $urandom_range(1, 8), $urandom_range(1, 8), 1, 1);
    repeat (3) send_tick(4'($urandom));
    phase_run(20);

    start <= 1'b0;
    while (issue_sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("Sent %0d items over seven configurations;", items_sent);
    $display("checked %0d results, %0d of them requests.",
             issue_sb.results_seen, issue_sb.requests_seen);
    $display("Mismatches: %0d", issue_sb.mismatches);
    if (issue_sb.mismatches == 0 && issue_sb.pending() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
